[src/quaternion_vector_rotate_core_assert.svh]
// Assertion macros for the quaternion vector rotation core.
// Used by the top level; no other dependencies.
`ifndef QUATERNION_VECTOR_ROTATE_CORE_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_CORE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define QVR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("qvr check failed: same-cycle implication");

// Next-cycle implication, off during reset.
`define QVR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("qvr check failed: next-cycle implication");

`endif

[src/qvr_pkg.sv]
// Types and fixed widths for the quaternion vector rotation core.
// No dependencies.
package qvr_pkg;

    localparam int QUAT_W = 16;
    localparam int VEC_W  = 24;

    // One input beat: quaternion in Q1.14, vector in Q11.12.
    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
        logic signed [VEC_W-1:0]  vec_x;
        logic signed [VEC_W-1:0]  vec_y;
        logic signed [VEC_W-1:0]  vec_z;
    } in_beat_t;

    // One result beat.
    typedef struct packed {
        logic signed [VEC_W-1:0] rot_x;
        logic signed [VEC_W-1:0] rot_y;
        logic signed [VEC_W-1:0] rot_z;
        logic                    zero_quat_error;
    } out_beat_t;

endpackage

[src/quaternion_vector_rotate_core.sv]
// Quaternion vector rotation core: v' = q (0,v) q^-1, pipelined, one beat per cycle unless m_ready stalls.
// Depends on qvr_pkg and quaternion_vector_rotate_core_assert.svh.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid / s_ready  | s_data  (qvr_pkg::in_beat_t)
//  m_      | out | m_valid / m_ready  | m_data  (qvr_pkg::out_beat_t)
//
// One beat enters per cycle unless the output stalls; each beat passes stages 1 to 6,
// the divider entry, a restoring divider of one quotient bit per stage, and the output register.
// All stages advance together whenever the output register is empty or taken.
// Reset (aresetn low, synchronous) clears the valid bits only.
// A stall at m_ready freezes every stage; nothing is dropped or repeated.
module quaternion_vector_rotate_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  qvr_pkg::in_beat_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output qvr_pkg::out_beat_t   m_data
);
    import qvr_pkg::*;

    `include "quaternion_vector_rotate_core_assert.svh"

    localparam int QW     = QUAT_W;
    localparam int VW     = VEC_W;
    localparam int SQ_W   = 2 * QW;
    localparam int PV_W   = QW + VW;
    localparam int N2_W   = 2 * QW + 2;
    localparam int S_W    = 2 * QW + 2;
    localparam int D_W    = QW + VW + 2;
    localparam int C_W    = QW + VW + 1;
    localparam int SV_W   = S_W + VW;
    localparam int DU_W   = D_W + 1 + QW;
    localparam int WC_W   = QW + 1 + C_W;
    localparam int NUM_W  = 2 * QW + VW + 3;
    localparam int DEN_W  = N2_W + 1;
    localparam int QB     = VW + 1;
    localparam int NN_W   = NUM_W + 1;
    localparam int CMP_W  = (NN_W > DEN_W + QB) ? NN_W : DEN_W + QB;
    localparam logic [QB-1:0] LIM_NEG = QB'(1) << (VW - 1);
    localparam logic [QB-1:0] MAX_POS = LIM_NEG - QB'(1);

    logic en;

    // whole pipe moves when the output slot frees up
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // ---------------- stage 1: squares and cross products ----------------
    logic                   v1_reg;
    logic signed [SQ_W-1:0] ww1_reg, xx1_reg, yy1_reg, zz1_reg;
    logic signed [PV_W-1:0] pv1_reg [9];
    logic signed [QW-1:0]   q1_reg [4];
    logic signed [VW-1:0]   vec1_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ww1_reg <= SQ_W'(s_data.quat_w) * SQ_W'(s_data.quat_w);
            xx1_reg <= SQ_W'(s_data.quat_x) * SQ_W'(s_data.quat_x);
            yy1_reg <= SQ_W'(s_data.quat_y) * SQ_W'(s_data.quat_y);
            zz1_reg <= SQ_W'(s_data.quat_z) * SQ_W'(s_data.quat_z);
            // dot terms
            pv1_reg[0] <= PV_W'(s_data.quat_x) * PV_W'(s_data.vec_x);
            pv1_reg[1] <= PV_W'(s_data.quat_y) * PV_W'(s_data.vec_y);
            pv1_reg[2] <= PV_W'(s_data.quat_z) * PV_W'(s_data.vec_z);
            // cross terms
            pv1_reg[3] <= PV_W'(s_data.quat_y) * PV_W'(s_data.vec_z);
            pv1_reg[4] <= PV_W'(s_data.quat_z) * PV_W'(s_data.vec_y);
            pv1_reg[5] <= PV_W'(s_data.quat_z) * PV_W'(s_data.vec_x);
            pv1_reg[6] <= PV_W'(s_data.quat_x) * PV_W'(s_data.vec_z);
            pv1_reg[7] <= PV_W'(s_data.quat_x) * PV_W'(s_data.vec_y);
            pv1_reg[8] <= PV_W'(s_data.quat_y) * PV_W'(s_data.vec_x);
            q1_reg[0]   <= s_data.quat_w;
            q1_reg[1]   <= s_data.quat_x;
            q1_reg[2]   <= s_data.quat_y;
            q1_reg[3]   <= s_data.quat_z;
            vec1_reg[0] <= s_data.vec_x;
            vec1_reg[1] <= s_data.vec_y;
            vec1_reg[2] <= s_data.vec_z;
        end
    end

    // ---------------- stage 2: norm, scalar term, dot, cross ----------------
    logic                   v2_reg;
    logic [N2_W-1:0]        n2_2_reg;
    logic                   zero2_reg;
    logic signed [S_W-1:0]  s2_reg;
    logic signed [D_W-1:0]  d2_reg;
    logic signed [C_W-1:0]  c2_reg [3];
    logic signed [QW-1:0]   q2_reg [4];
    logic signed [VW-1:0]   vec2_reg [3];
    logic [N2_W-1:0]        n2_next;

    assign n2_next = N2_W'(ww1_reg) + N2_W'(xx1_reg) + N2_W'(yy1_reg) + N2_W'(zz1_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n2_2_reg  <= n2_next;
            zero2_reg <= (n2_next == '0);
            s2_reg    <= S_W'(ww1_reg) - S_W'(xx1_reg) - S_W'(yy1_reg) - S_W'(zz1_reg);
            d2_reg    <= D_W'(pv1_reg[0]) + D_W'(pv1_reg[1]) + D_W'(pv1_reg[2]);
            c2_reg[0] <= C_W'(pv1_reg[3]) - C_W'(pv1_reg[4]);
            c2_reg[1] <= C_W'(pv1_reg[5]) - C_W'(pv1_reg[6]);
            c2_reg[2] <= C_W'(pv1_reg[7]) - C_W'(pv1_reg[8]);
            q2_reg    <= q1_reg;
            vec2_reg  <= vec1_reg;
        end
    end

    // ---------------- stage 3: the three product terms per axis ----------------
    logic                   v3_reg;
    logic [N2_W-1:0]        n2_3_reg;
    logic                   zero3_reg;
    logic signed [SV_W-1:0] sv3_reg [3];
    logic signed [DU_W-1:0] du3_reg [3];
    logic signed [WC_W-1:0] wc3_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n2_3_reg  <= n2_2_reg;
            zero3_reg <= zero2_reg;
            for (int l = 0; l < 3; l++) begin
                sv3_reg[l] <= SV_W'(s2_reg) * SV_W'(vec2_reg[l]);
                du3_reg[l] <= (DU_W'(d2_reg) <<< 1) * DU_W'(q2_reg[l+1]);
                wc3_reg[l] <= (WC_W'(q2_reg[0]) <<< 1) * WC_W'(c2_reg[l]);
            end
        end
    end

    // ---------------- stage 4: numerators ----------------
    logic                    v4_reg;
    logic [N2_W-1:0]         n2_4_reg;
    logic                    zero4_reg;
    logic signed [NUM_W-1:0] num4_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n2_4_reg  <= n2_3_reg;
            zero4_reg <= zero3_reg;
            for (int l = 0; l < 3; l++) begin
                num4_reg[l] <= NUM_W'(sv3_reg[l]) + NUM_W'(du3_reg[l]) + NUM_W'(wc3_reg[l]);
            end
        end
    end

    // ---------------- stage 5: sign and magnitude ----------------
    logic             v5_reg;
    logic [N2_W-1:0]  n2_5_reg;
    logic             zero5_reg;
    logic             neg5_reg [3];
    logic [NUM_W-1:0] mag5_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n2_5_reg  <= n2_4_reg;
            zero5_reg <= zero4_reg;
            for (int l = 0; l < 3; l++) begin
                neg5_reg[l] <= num4_reg[l][NUM_W-1];
                mag5_reg[l] <= num4_reg[l][NUM_W-1] ? NUM_W'(-num4_reg[l])
                                                    : NUM_W'(num4_reg[l]);
            end
        end
    end

    // ---------------- stage 6: rounding dividend 2|n|+n2, divisor 2*n2 ----------------
    logic             v6_reg;
    logic [DEN_W-1:0] den6_reg;
    logic             zero6_reg;
    logic             neg6_reg [3];
    logic [CMP_W-1:0] nn6_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den6_reg  <= {n2_5_reg, 1'b0};
            zero6_reg <= zero5_reg;
            for (int l = 0; l < 3; l++) begin
                neg6_reg[l] <= neg5_reg[l];
                nn6_reg[l]  <= CMP_W'({mag5_reg[l], 1'b0}) + CMP_W'(n2_5_reg);
            end
        end
    end

    // ---------------- divider: overflow check, then one quotient bit per stage ----------------
    logic             dv_valid_reg [QB+1];
    logic [DEN_W-1:0] dv_den_reg   [QB+1];
    logic             dv_zero_reg  [QB+1];
    logic             dv_neg_reg   [QB+1][3];
    logic             dv_ovf_reg   [QB+1][3];
    logic [CMP_W-1:0] dv_rem_reg   [QB+1][3];
    logic [QB-1:0]    dv_quo_reg   [QB+1][3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= QB; j++) begin
                dv_valid_reg[j] <= 1'b0;
            end
        end else if (en) begin
            dv_valid_reg[0] <= v6_reg;
            for (int j = 0; j < QB; j++) begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
        end
    end

    // entry: quotient that would not fit QB bits is flagged and saturated later
    always_ff @(posedge aclk) begin
        if (en) begin
            dv_den_reg[0]  <= den6_reg;
            dv_zero_reg[0] <= zero6_reg;
            for (int l = 0; l < 3; l++) begin
                dv_neg_reg[0][l] <= neg6_reg[l];
                dv_ovf_reg[0][l] <= nn6_reg[l] >= (CMP_W'(den6_reg) << QB);
                dv_rem_reg[0][l] <= nn6_reg[l];
                dv_quo_reg[0][l] <= '0;
            end
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int BIT = QB - 1 - j;
        logic [CMP_W-1:0] trial;

        assign trial = CMP_W'(dv_den_reg[j]) << BIT;

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_den_reg[j+1]  <= dv_den_reg[j];
                dv_zero_reg[j+1] <= dv_zero_reg[j];
                for (int l = 0; l < 3; l++) begin
                    dv_neg_reg[j+1][l] <= dv_neg_reg[j][l];
                    dv_ovf_reg[j+1][l] <= dv_ovf_reg[j][l];
                    if (dv_rem_reg[j][l] >= trial) begin
                        dv_rem_reg[j+1][l] <= dv_rem_reg[j][l] - trial;
                        dv_quo_reg[j+1][l] <= dv_quo_reg[j][l] | (QB'(1) << BIT);
                    end else begin
                        dv_rem_reg[j+1][l] <= dv_rem_reg[j][l];
                        dv_quo_reg[j+1][l] <= dv_quo_reg[j][l];
                    end
                end
            end
        end
    end

    // ---------------- output: saturate, apply sign, zero-quaternion override ----------------
    logic                 m_valid_reg;
    out_beat_t            m_data_reg;
    out_beat_t            m_data_next;
    logic [QB-1:0]        qmag;
    logic [VW-1:0]        rot [3];

    always_comb begin
        qmag        = '0;
        m_data_next = '0;
        for (int l = 0; l < 3; l++) begin
            qmag = dv_ovf_reg[QB][l] ? '1 : dv_quo_reg[QB][l];
            if (dv_neg_reg[QB][l]) begin
                if (qmag > LIM_NEG) begin
                    qmag = LIM_NEG;
                end
                rot[l] = VW'(-qmag);
            end else begin
                if (qmag > MAX_POS) begin
                    qmag = MAX_POS;
                end
                rot[l] = VW'(qmag);
            end
            if (dv_zero_reg[QB]) begin
                rot[l] = '0;
            end
        end
        m_data_next.rot_x           = rot[0];
        m_data_next.rot_y           = rot[1];
        m_data_next.rot_z           = rot[2];
        m_data_next.zero_quat_error = dv_zero_reg[QB];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_valid_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- checks ----------------
    `QVR_ASSERT_NOW(a_zero_gives_zero, aclk, aresetn, m_valid && m_data.zero_quat_error, m_data.rot_x == '0 && m_data.rot_y == '0 && m_data.rot_z == '0)
    `QVR_ASSERT_NEXT(a_tail_reaches_out, aclk, aresetn, dv_valid_reg[QB] && s_ready, m_valid)
    `QVR_ASSERT_NEXT(a_stall_freezes_pipe, aclk, aresetn, !s_ready && v6_reg, v6_reg && $stable(den6_reg))

endmodule
